// ===== rtl/mau_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular arithmetic unit package
// Widths, function codes, datapath operations and shared helpers.
// ----------------------------------------------------------------------------
package mau_pkg;

    localparam int VALUE_WIDTH = 31;
    localparam int OPB_WIDTH   = 32;
    localparam int FUNC_WIDTH  = 3;
    localparam int DIV_STEPS   = OPB_WIDTH;
    localparam int CNT_WIDTH   = $clog2(DIV_STEPS + 1);
    localparam int ADDR_WIDTH  = 3;
    localparam logic [VALUE_WIDTH-1:0] MODULUS_RESET = VALUE_WIDTH'(1000000007);

    localparam logic [FUNC_WIDTH-1:0] FN_ADD    = 3'd0;
    localparam logic [FUNC_WIDTH-1:0] FN_SUB    = 3'd1;
    localparam logic [FUNC_WIDTH-1:0] FN_NEGATE = 3'd2;
    localparam logic [FUNC_WIDTH-1:0] FN_MUL    = 3'd3;
    localparam logic [FUNC_WIDTH-1:0] FN_POWER  = 3'd4;
    localparam logic [FUNC_WIDTH-1:0] FN_INV    = 3'd5;
    localparam logic [FUNC_WIDTH-1:0] FN_DIVIDE = 3'd6;

    localparam logic [ADDR_WIDTH-1:0] REG_MODULUS = 3'd0;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_DIV_STEP,
        OP_SET_X,
        OP_SET_Y,
        OP_ALU,
        OP_MUL_XY,
        OP_MUL_STEP,
        OP_WB_RES,
        OP_EUC_X,
        OP_EUC_Y,
        OP_DIV_EUC,
        OP_MUL_QT,
        OP_EUC_UPD,
        OP_INV_RES,
        OP_FAIL,
        OP_MUL_XI,
        OP_POW_INIT_X,
        OP_POW_INIT_INV,
        OP_MUL_RB,
        OP_POW_RES,
        OP_MUL_BB,
        OP_POW_BASE
    } t_op;

    typedef struct packed {
        t_op  op;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic                  m_small;
        logic                  div_done;
        logic                  mul_done;
        logic                  r1_zero;
        logic                  r0_one;
        logic                  e_zero;
        logic                  e_lsb;
        logic                  b_neg;
        logic [FUNC_WIDTH-1:0] func;
    } t_stat;

    function automatic logic [VALUE_WIDTH-1:0] add_mod(
        input logic [VALUE_WIDTH-1:0] x,
        input logic [VALUE_WIDTH-1:0] y,
        input logic [VALUE_WIDTH-1:0] m
    );
        logic [VALUE_WIDTH:0] s;
        s = {1'b0, x} + {1'b0, y};
        if (s >= {1'b0, m}) begin
            s = s - {1'b0, m};
        end
        return s[VALUE_WIDTH-1:0];
    endfunction

    function automatic logic [VALUE_WIDTH-1:0] sub_mod(
        input logic [VALUE_WIDTH-1:0] x,
        input logic [VALUE_WIDTH-1:0] y,
        input logic [VALUE_WIDTH-1:0] m
    );
        logic [VALUE_WIDTH:0] s;
        if (x >= y) begin
            s = {1'b0, x} - {1'b0, y};
        end else begin
            s = {1'b0, x} + {1'b0, m} - {1'b0, y};
        end
        return s[VALUE_WIDTH-1:0];
    endfunction

endpackage

// ===== rtl/mau_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular arithmetic unit request channel
// Valid/ready channel carrying the function code and both operands.
// ----------------------------------------------------------------------------
interface mau_in_if;
    logic                                 valid;
    logic                                 ready;
    logic [mau_pkg::FUNC_WIDTH-1:0]       func;
    logic [mau_pkg::VALUE_WIDTH-1:0]      operand_a;
    logic signed [mau_pkg::OPB_WIDTH-1:0] operand_b;

    modport source (output valid, func, operand_a, operand_b, input ready);
    modport sink   (input valid, func, operand_a, operand_b, output ready);
endinterface

// ===== rtl/mau_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular arithmetic unit response channel
// Valid/ready channel carrying the residue and the status bit.
// ----------------------------------------------------------------------------
interface mau_out_if;
    logic                            valid;
    logic                            ready;
    logic [mau_pkg::VALUE_WIDTH-1:0] result;
    logic                            status;

    modport source (output valid, result, status, input ready);
    modport sink   (input valid, result, status, output ready);
endinterface

// ===== rtl/mau_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular arithmetic unit datapath
// Bit-serial divider, shift-and-add modular multiplier and operand registers.
// ----------------------------------------------------------------------------
module mau_dp (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  mau_pkg::t_cmd                        i_cmd,
    input  logic [mau_pkg::VALUE_WIDTH-1:0]      i_modulus,
    input  logic [mau_pkg::FUNC_WIDTH-1:0]       i_func,
    input  logic [mau_pkg::VALUE_WIDTH-1:0]      i_operand_a,
    input  logic [mau_pkg::OPB_WIDTH-1:0]        i_operand_b,
    output mau_pkg::t_stat                       o_stat,
    output logic [mau_pkg::VALUE_WIDTH-1:0]      o_result,
    output logic                                 o_status
);
    localparam int VW = mau_pkg::VALUE_WIDTH;
    localparam int BW = mau_pkg::OPB_WIDTH;
    localparam int CW = mau_pkg::CNT_WIDTH;

    logic [mau_pkg::FUNC_WIDTH-1:0] r_func, n_func;
    logic [BW-1:0] r_braw, n_braw;
    logic [VW-1:0] r_x, n_x, r_y, n_y;
    logic [BW-1:0] r_dq, n_dq;
    logic [VW-1:0] r_drem, n_drem, r_dd, n_dd;
    logic [CW-1:0] r_dcnt, n_dcnt;
    logic [VW-1:0] r_ma, n_ma, r_mb, n_mb, r_macc, n_macc;
    logic [VW-1:0] r_r0, n_r0, r_r1, n_r1, r_t0, n_t0, r_t1, n_t1;
    logic [VW-1:0] r_base, n_base, r_res, n_res;
    logic          r_st, n_st;
    logic [BW-1:0] r_e, n_e;

    logic [BW-1:0] bmag;
    logic [BW-1:0] dtrial;
    logic [BW-1:0] ddiff;
    logic          dge;
    logic [VW-1:0] qm;
    logic [VW-1:0] yfix;
    logic [VW-1:0] alu;
    logic [VW-1:0] m;

    assign m      = i_modulus;
    assign bmag   = r_braw[BW-1] ? (~r_braw + BW'(1)) : r_braw;
    assign dtrial = {r_drem, r_dq[BW-1]};
    assign dge    = dtrial >= {1'b0, r_dd};
    assign ddiff  = dtrial - {1'b0, r_dd};
    assign qm     = (r_dq[VW-1:0] >= m) ? (r_dq[VW-1:0] - m) : r_dq[VW-1:0];
    assign yfix   = (r_braw[BW-1] && (r_drem != '0)) ? (m - r_drem) : r_drem;

    always_comb begin
        unique case (r_func)
            mau_pkg::FN_ADD:    alu = mau_pkg::add_mod(r_x, r_y, m);
            mau_pkg::FN_SUB:    alu = mau_pkg::sub_mod(r_x, r_y, m);
            mau_pkg::FN_NEGATE: alu = mau_pkg::sub_mod('0, r_x, m);
            default:            alu = '0;
        endcase
    end

    always_comb begin
        n_func = r_func; n_braw = r_braw; n_x = r_x; n_y = r_y;
        n_dq = r_dq; n_drem = r_drem; n_dd = r_dd; n_dcnt = r_dcnt;
        n_ma = r_ma; n_mb = r_mb; n_macc = r_macc;
        n_r0 = r_r0; n_r1 = r_r1; n_t0 = r_t0; n_t1 = r_t1;
        n_base = r_base; n_res = r_res; n_st = r_st; n_e = r_e;
        unique case (i_cmd.op)
            mau_pkg::OP_NONE: begin
            end
            mau_pkg::OP_LOAD: begin
                n_func = i_func;
                n_braw = i_operand_b;
                n_dq   = {1'b0, i_operand_a};
                n_drem = '0;
                n_dd   = m;
                n_dcnt = CW'(mau_pkg::DIV_STEPS);
                n_res  = '0;
                n_st   = 1'b0;
            end
            mau_pkg::OP_DIV_STEP: begin
                n_drem = dge ? ddiff[VW-1:0] : dtrial[VW-1:0];
                n_dq   = {r_dq[BW-2:0], dge};
                n_dcnt = r_dcnt - CW'(1);
            end
            mau_pkg::OP_SET_X: begin
                n_x    = r_drem;
                n_dq   = bmag;
                n_drem = '0;
                n_dd   = m;
                n_dcnt = CW'(mau_pkg::DIV_STEPS);
            end
            mau_pkg::OP_SET_Y: begin
                n_y = yfix;
            end
            mau_pkg::OP_ALU: begin
                n_res = alu;
            end
            mau_pkg::OP_MUL_XY: begin
                n_ma = r_x; n_mb = r_y; n_macc = '0;
            end
            mau_pkg::OP_MUL_STEP: begin
                if (r_mb[0]) begin
                    n_macc = mau_pkg::add_mod(r_macc, r_ma, m);
                end
                n_ma = mau_pkg::add_mod(r_ma, r_ma, m);
                n_mb = {1'b0, r_mb[VW-1:1]};
            end
            mau_pkg::OP_WB_RES: begin
                n_res = r_macc;
            end
            mau_pkg::OP_EUC_X: begin
                n_r0 = m; n_r1 = r_x; n_t0 = '0; n_t1 = VW'(1);
            end
            mau_pkg::OP_EUC_Y: begin
                n_r0 = m; n_r1 = r_y; n_t0 = '0; n_t1 = VW'(1);
            end
            mau_pkg::OP_DIV_EUC: begin
                n_dq   = {1'b0, r_r0};
                n_drem = '0;
                n_dd   = r_r1;
                n_dcnt = CW'(mau_pkg::DIV_STEPS);
            end
            mau_pkg::OP_MUL_QT: begin
                n_ma = qm; n_mb = r_t1; n_macc = '0;
            end
            mau_pkg::OP_EUC_UPD: begin
                n_r0 = r_r1;
                n_r1 = r_drem;
                n_t0 = r_t1;
                n_t1 = mau_pkg::sub_mod(r_t0, r_macc, m);
            end
            mau_pkg::OP_INV_RES: begin
                n_res = r_t0;
            end
            mau_pkg::OP_FAIL: begin
                n_res = '0;
                n_st  = 1'b1;
            end
            mau_pkg::OP_MUL_XI: begin
                n_ma = r_x; n_mb = r_t0; n_macc = '0;
            end
            mau_pkg::OP_POW_INIT_X: begin
                n_base = r_x; n_res = VW'(1); n_e = bmag;
            end
            mau_pkg::OP_POW_INIT_INV: begin
                n_base = r_t0; n_res = VW'(1); n_e = bmag;
            end
            mau_pkg::OP_MUL_RB: begin
                n_ma = r_res; n_mb = r_base; n_macc = '0;
            end
            mau_pkg::OP_POW_RES: begin
                n_res = r_macc; n_ma = r_base; n_mb = r_base; n_macc = '0;
            end
            mau_pkg::OP_MUL_BB: begin
                n_ma = r_base; n_mb = r_base; n_macc = '0;
            end
            mau_pkg::OP_POW_BASE: begin
                n_base = r_macc;
                n_e    = {1'b0, r_e[BW-1:1]};
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dcnt <= '0;
        end else begin
            r_dcnt <= n_dcnt;
        end
        r_func <= n_func; r_braw <= n_braw; r_x <= n_x; r_y <= n_y;
        r_dq <= n_dq; r_drem <= n_drem; r_dd <= n_dd;
        r_ma <= n_ma; r_mb <= n_mb; r_macc <= n_macc;
        r_r0 <= n_r0; r_r1 <= n_r1; r_t0 <= n_t0; r_t1 <= n_t1;
        r_base <= n_base; r_res <= n_res; r_st <= n_st; r_e <= n_e;
    end

    assign o_stat.m_small  = (m < VW'(2));
    assign o_stat.div_done = (r_dcnt == '0);
    assign o_stat.mul_done = (r_mb == '0);
    assign o_stat.r1_zero  = (r_r1 == '0);
    assign o_stat.r0_one   = (r_r0 == VW'(1));
    assign o_stat.e_zero   = (r_e == '0);
    assign o_stat.e_lsb    = r_e[0];
    assign o_stat.b_neg    = r_braw[BW-1];
    assign o_stat.func     = r_func;
    assign o_result        = r_res;
    assign o_status        = r_st;

endmodule

// ===== rtl/mau_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular arithmetic unit controller
// Sequences reduction, multiply, Euclid and square-and-multiply steps.
// ----------------------------------------------------------------------------
module mau_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_slot_free,
    input  mau_pkg::t_stat i_stat,
    output logic           o_in_ready,
    output mau_pkg::t_cmd  o_cmd
);
    typedef enum logic [12:0] {
        S_IDLE     = 13'b0000000000001,
        S_RED_A    = 13'b0000000000010,
        S_RED_B    = 13'b0000000000100,
        S_DISPATCH = 13'b0000000001000,
        S_MUL_XY   = 13'b0000000010000,
        S_EUC_TEST = 13'b0000000100000,
        S_EUC_DIV  = 13'b0000001000000,
        S_EUC_MUL  = 13'b0000010000000,
        S_POW_TEST = 13'b0000100000000,
        S_POW_RM   = 13'b0001000000000,
        S_POW_BM   = 13'b0010000000000,
        S_DIV_MUL  = 13'b0100000000000,
        S_EMIT     = 13'b1000000000000
    } t_state;

    t_state r_state, n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state    = r_state;
        o_cmd.op   = mau_pkg::OP_NONE;
        o_cmd.emit = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = mau_pkg::OP_LOAD;
                    n_state  = i_stat.m_small ? S_EMIT : S_RED_A;
                end
            end
            S_RED_A: begin
                if (i_stat.div_done) begin
                    o_cmd.op = mau_pkg::OP_SET_X;
                    n_state  = S_RED_B;
                end else begin
                    o_cmd.op = mau_pkg::OP_DIV_STEP;
                end
            end
            S_RED_B: begin
                if (i_stat.div_done) begin
                    o_cmd.op = mau_pkg::OP_SET_Y;
                    n_state  = S_DISPATCH;
                end else begin
                    o_cmd.op = mau_pkg::OP_DIV_STEP;
                end
            end
            S_DISPATCH: begin
                priority if (i_stat.func == mau_pkg::FN_MUL) begin
                    o_cmd.op = mau_pkg::OP_MUL_XY;
                    n_state  = S_MUL_XY;
                end else if (i_stat.func == mau_pkg::FN_POWER && !i_stat.b_neg) begin
                    o_cmd.op = mau_pkg::OP_POW_INIT_X;
                    n_state  = S_POW_TEST;
                end else if (i_stat.func == mau_pkg::FN_POWER
                             || i_stat.func == mau_pkg::FN_INV) begin
                    o_cmd.op = mau_pkg::OP_EUC_X;
                    n_state  = S_EUC_TEST;
                end else if (i_stat.func == mau_pkg::FN_DIVIDE) begin
                    o_cmd.op = mau_pkg::OP_EUC_Y;
                    n_state  = S_EUC_TEST;
                end else begin
                    o_cmd.op = mau_pkg::OP_ALU;
                    n_state  = S_EMIT;
                end
            end
            S_MUL_XY, S_DIV_MUL: begin
                if (i_stat.mul_done) begin
                    o_cmd.op = mau_pkg::OP_WB_RES;
                    n_state  = S_EMIT;
                end else begin
                    o_cmd.op = mau_pkg::OP_MUL_STEP;
                end
            end
            S_EUC_TEST: begin
                priority if (!i_stat.r1_zero) begin
                    o_cmd.op = mau_pkg::OP_DIV_EUC;
                    n_state  = S_EUC_DIV;
                end else if (!i_stat.r0_one) begin
                    o_cmd.op = mau_pkg::OP_FAIL;
                    n_state  = S_EMIT;
                end else if (i_stat.func == mau_pkg::FN_INV) begin
                    o_cmd.op = mau_pkg::OP_INV_RES;
                    n_state  = S_EMIT;
                end else if (i_stat.func == mau_pkg::FN_DIVIDE) begin
                    o_cmd.op = mau_pkg::OP_MUL_XI;
                    n_state  = S_DIV_MUL;
                end else begin
                    o_cmd.op = mau_pkg::OP_POW_INIT_INV;
                    n_state  = S_POW_TEST;
                end
            end
            S_EUC_DIV: begin
                if (i_stat.div_done) begin
                    o_cmd.op = mau_pkg::OP_MUL_QT;
                    n_state  = S_EUC_MUL;
                end else begin
                    o_cmd.op = mau_pkg::OP_DIV_STEP;
                end
            end
            S_EUC_MUL: begin
                if (i_stat.mul_done) begin
                    o_cmd.op = mau_pkg::OP_EUC_UPD;
                    n_state  = S_EUC_TEST;
                end else begin
                    o_cmd.op = mau_pkg::OP_MUL_STEP;
                end
            end
            S_POW_TEST: begin
                priority if (i_stat.e_zero) begin
                    n_state = S_EMIT;
                end else if (i_stat.e_lsb) begin
                    o_cmd.op = mau_pkg::OP_MUL_RB;
                    n_state  = S_POW_RM;
                end else begin
                    o_cmd.op = mau_pkg::OP_MUL_BB;
                    n_state  = S_POW_BM;
                end
            end
            S_POW_RM: begin
                if (i_stat.mul_done) begin
                    o_cmd.op = mau_pkg::OP_POW_RES;
                    n_state  = S_POW_BM;
                end else begin
                    o_cmd.op = mau_pkg::OP_MUL_STEP;
                end
            end
            S_POW_BM: begin
                if (i_stat.mul_done) begin
                    o_cmd.op = mau_pkg::OP_POW_BASE;
                    n_state  = S_POW_TEST;
                end else begin
                    o_cmd.op = mau_pkg::OP_MUL_STEP;
                end
            end
            S_EMIT: begin
                if (i_slot_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/modular_arithmetic_unit_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular arithmetic unit
// Add, subtract, negate, multiply, power, inverse and divide modulo a
// programmable modulus, one request word at a time.
//
// Usage: write the modulus over APB at address 0 while idle (reset value
// 1000000007). Send request words on i_in; each gives one response word on
// o_out holding the residue and a status bit (1: no inverse exists).
// Both operands are reduced by a bit-serial divider, one after the other.
// Multiply then runs the shift-and-add multiplier. Inverse and divide run
// Euclid, each quotient step using the divider and then the multiplier.
// Power runs square-and-multiply over up to 32 exponent bits, after an
// inverse when the exponent is negative. One request is worked on at a
// time; a new one is taken once the previous response sits in the output
// register. A stalled receiver holds the response word and the block waits
// before delivering the next one. Reset returns the controller to idle,
// empties the output register and restores the modulus.
// ----------------------------------------------------------------------------
module modular_arithmetic_unit_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    mau_in_if.sink                             i_in,
    mau_out_if.source                          o_out,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [mau_pkg::ADDR_WIDTH-1:0]     paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);
    localparam int VW = mau_pkg::VALUE_WIDTH;

    logic [VW-1:0]  r_modulus;
    logic           r_out_valid;
    logic [VW-1:0]  r_result;
    logic           r_status;
    logic           slot_free;
    mau_pkg::t_cmd  cmd;
    mau_pkg::t_stat stat;
    logic [VW-1:0]  dp_result;
    logic           dp_status;
    logic           cfg_wr;

    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite && (paddr == mau_pkg::REG_MODULUS);
    assign prdata    = (paddr == mau_pkg::REG_MODULUS) ? {1'b0, r_modulus} : '0;
    assign slot_free = !r_out_valid || o_out.ready;

    mau_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_slot_free (slot_free),
        .i_stat      (stat),
        .o_in_ready  (i_in.ready),
        .o_cmd       (cmd)
    );

    mau_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_modulus   (r_modulus),
        .i_func      (i_in.func),
        .i_operand_a (i_in.operand_a),
        .i_operand_b (i_in.operand_b),
        .o_stat      (stat),
        .o_result    (dp_result),
        .o_status    (dp_status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus   <= mau_pkg::MODULUS_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (cfg_wr) begin
                r_modulus <= pwdata[VW-1:0];
            end
            if (cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (cmd.emit) begin
            r_result <= dp_result;
            r_status <= dp_status;
        end
    end

    assign o_out.valid  = r_out_valid;
    assign o_out.result = r_result;
    assign o_out.status = r_status;

`ifndef SYNTHESIS
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> !i_in.ready)
        else $error("request word taken while busy");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> slot_free)
        else $error("response word overwritten");
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.status |-> o_out.result == '0)
        else $error("failed response carries nonzero residue");
`endif

endmodule

// ===== verif/mau_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular arithmetic unit checker
// Watches the request, response and APB ports, tracks the modulus, predicts
// each response word from the request word and compares in order.
// ----------------------------------------------------------------------------
module mau_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    mau_in_if                              i_req,
    mau_out_if                             i_rsp,
    input  logic                           i_psel,
    input  logic                           i_penable,
    input  logic                           i_pwrite,
    input  logic                           i_pready,
    input  logic [mau_pkg::ADDR_WIDTH-1:0] i_paddr,
    input  logic [31:0]                    i_pwdata,
    output int                             o_errors,
    output int                             o_pending,
    output int                             o_checked,
    output int                             o_no_inverse
);
    localparam int VW = mau_pkg::VALUE_WIDTH;
    localparam int FW = mau_pkg::FUNC_WIDTH;
    localparam int BW = mau_pkg::OPB_WIDTH;

    typedef struct packed {
        logic [VW-1:0] result;
        logic          status;
    } t_residue;

    t_residue      residue_q[$];
    logic [VW-1:0] cur_modulus;

    function automatic longint unsigned mul_mod(input longint unsigned x,
                                                input longint unsigned y,
                                                input longint unsigned m);
        return (x * y) % m;
    endfunction

    function automatic bit inv_mod(input longint a, input longint m, output longint r);
        longint r0, r1, t0, t1, q, rn, tn;
        r0 = m; r1 = a; t0 = 0; t1 = 1;
        while (r1 != 0) begin
            q  = r0 / r1;
            rn = r0 - q * r1;
            tn = t0 - q * t1;
            r0 = r1; r1 = rn;
            t0 = t1; t1 = tn;
        end
        r = 0;
        if (r0 != 1) return 1'b0;
        if (t0 < 0) t0 = t0 + m;
        r = t0 % m;
        return 1'b1;
    endfunction

    function automatic t_residue predict_residue(input logic [FW-1:0] f,
                                                 input logic [VW-1:0] op_a,
                                                 input logic [BW-1:0] op_b,
                                                 input logic [VW-1:0] mod_reg);
        t_residue        p;
        longint          m, a, b, bmag, inv, base, e, res;
        bit              bneg, ok;
        p = '0;
        m = longint'(mod_reg);
        if (m < 2) return p;
        bneg = op_b[BW-1];
        bmag = bneg ? longint'(32'(-op_b)) : longint'(op_b);
        a    = longint'(op_a) % m;
        b    = bmag % m;
        if (bneg && b != 0) b = m - b;
        res  = 0;
        case (f)
            mau_pkg::FN_ADD:    res = (a + b) % m;
            mau_pkg::FN_SUB:    res = (a >= b) ? a - b : a + m - b;
            mau_pkg::FN_NEGATE: res = (a != 0) ? m - a : 0;
            mau_pkg::FN_MUL:    res = mul_mod(a, b, m);
            mau_pkg::FN_POWER: begin
                base = a;
                e    = bmag;
                ok   = 1'b1;
                if (bneg) begin
                    ok   = inv_mod(a, m, inv);
                    base = inv;
                end
                if (!ok) begin
                    p.status = 1'b1;
                end else begin
                    res = 1;
                    while (e != 0) begin
                        if (e[0]) res = mul_mod(res, base, m);
                        base = mul_mod(base, base, m);
                        e = e >> 1;
                    end
                end
            end
            mau_pkg::FN_INV: begin
                if (inv_mod(a, m, inv)) res = inv;
                else p.status = 1'b1;
            end
            mau_pkg::FN_DIVIDE: begin
                if (inv_mod(b, m, inv)) res = mul_mod(a, inv, m);
                else p.status = 1'b1;
            end
            default: res = 0;
        endcase
        p.result = res[VW-1:0];
        return p;
    endfunction

    always @(posedge i_clk) begin
        t_residue want;
        if (!i_rst_n) begin
            cur_modulus  = mau_pkg::MODULUS_RESET;
            o_errors     = 0;
            o_checked    = 0;
            o_no_inverse = 0;
            residue_q.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready &&
                i_paddr == mau_pkg::REG_MODULUS) begin
                cur_modulus = i_pwdata[VW-1:0];
            end
            if (i_req.valid && i_req.ready) begin
                residue_q = {residue_q, predict_residue(i_req.func, i_req.operand_a,
                                                        i_req.operand_b, cur_modulus)};
            end
            if (i_rsp.valid && i_rsp.ready) begin
                if (residue_q.size() == 0) begin
                    o_errors++;
                    $display("%0t: unexpected word result=%0d status=%0b", $time,
                             i_rsp.result, i_rsp.status);
                end else begin
                    want = residue_q.pop_front();
                    o_checked++;
                    if (want.status) o_no_inverse++;
                    if (want.result !== i_rsp.result) begin
                        o_errors++;
                        $display("%0t: result expected %0d actual %0d", $time,
                                 want.result, i_rsp.result);
                    end
                    if (want.status !== i_rsp.status) begin
                        o_errors++;
                        $display("%0t: status expected %0b actual %0b", $time,
                                 want.status, i_rsp.status);
                    end
                end
            end
        end
        o_pending = residue_q.size();
    end
endmodule

// ===== verif/modular_arithmetic_unit_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular arithmetic unit testbench
// Drives directed and random request words over several moduli and idle
// patterns, programs the modulus over APB and reports the checker verdict.
// ----------------------------------------------------------------------------
module modular_arithmetic_unit_top_test;

    localparam int WATCHDOG_LIMIT = 200000;
    localparam int PHASE_ITEMS    = 230;
    localparam int HOLD_CYCLES    = 600;
    localparam int VW             = mau_pkg::VALUE_WIDTH;
    localparam int FW             = mau_pkg::FUNC_WIDTH;
    localparam int BW             = mau_pkg::OPB_WIDTH;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           psel = 1'b0;
    logic                           penable = 1'b0;
    logic                           pwrite = 1'b0;
    logic [mau_pkg::ADDR_WIDTH-1:0] paddr = '0;
    logic [31:0]                    pwdata = '0;
    logic [31:0]                    prdata;
    logic                           pready;

    int errors, pending, checked, no_inverse;
    int tx_idle_pct, rx_idle_pct;
    bit hold_req;
    int words_sent;
    logic [VW-1:0] modulus_now;

    mau_in_if  req_bus ();
    mau_out_if rsp_bus ();

    modular_arithmetic_unit_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_bus),
        .o_out   (rsp_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    mau_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_bus),
        .i_rsp        (rsp_bus),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_errors     (errors),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_no_inverse (no_inverse)
    );

    always #5 i_clk = ~i_clk;

    // drive ready: random stalls, or a long hold when asked
    initial begin
        bit held;
        held          = 1'b0;
        rsp_bus.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !held) begin
                held = 1'b1;
                repeat (HOLD_CYCLES) begin
                    rsp_bus.ready <= 1'b0;
                    @(posedge i_clk);
                end
            end
            rsp_bus.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    initial begin
        int idle_cnt;
        idle_cnt = 0;
        while (idle_cnt < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
                psel || !i_rst_n)
                idle_cnt = 0;
            else
                idle_cnt++;
        end
        $display("modular_arithmetic_unit_top_test NOT OK");
        $finish;
    end

    task automatic send_word(input logic [FW-1:0] f, input logic [VW-1:0] a,
                             input logic [BW-1:0] b);
        while ($urandom_range(99) < tx_idle_pct) begin
            req_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_bus.valid     <= 1'b1;
        req_bus.func      <= f;
        req_bus.operand_a <= a;
        req_bus.operand_b <= b;
        @(posedge i_clk);
        while (!req_bus.ready) @(posedge i_clk);
        words_sent++;
    endtask

    task automatic write_modulus(input logic [VW-1:0] m);
        req_bus.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= mau_pkg::REG_MODULUS;
        pwdata  <= 32'(m);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        modulus_now = m;
    endtask

    function automatic logic [VW-1:0] rand_a();
        logic [VW-1:0] v;
        case ($urandom_range(3))
            0: v = VW'($urandom_range(0, 20));
            1: v = modulus_now - VW'($urandom_range(0, 2));
            default: v = VW'($urandom);
        endcase
        if (&v) v = v - 1'b1;
        return v;
    endfunction

    function automatic logic [BW-1:0] rand_b(input logic [FW-1:0] f);
        logic [BW-1:0] v;
        if (f == mau_pkg::FN_POWER && $urandom_range(9) < 8) begin
            v = BW'($urandom_range(0, 40));
        end else begin
            case ($urandom_range(3))
                0: v = BW'($urandom_range(0, 20));
                1: v = BW'(modulus_now) + BW'($urandom_range(0, 2));
                default: v = $urandom & 32'h7FFF_FFFF;
            endcase
            if (v == 32'h7FFF_FFFF) v = v - 1;
        end
        if ($urandom_range(1)) v = -v;
        return v;
    endfunction

    initial begin
        logic [VW-1:0] moduli[6];
        logic [FW-1:0] f;
        logic [VW-1:0] amax;
        req_bus.valid     = 1'b0;
        req_bus.func      = mau_pkg::FN_ADD;
        req_bus.operand_a = '0;
        req_bus.operand_b = '0;
        moduli = '{VW'(2), VW'(2147483647), VW'(998244353),
                   VW'(1000000), VW'(12), VW'(1000000007)};
        amax        = VW'(2147483646);
        modulus_now = mau_pkg::MODULUS_RESET;
        tx_idle_pct = 10;
        rx_idle_pct = 85;
        hold_req    = 1'b0;
        words_sent  = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_word(mau_pkg::FN_ADD, amax, 32'sd2147483646);
        send_word(mau_pkg::FN_ADD, VW'(0), -32'sd2147483647);
        send_word(mau_pkg::FN_SUB, VW'(0), 32'sd2147483646);
        send_word(mau_pkg::FN_SUB, amax, 32'sd5);
        send_word(mau_pkg::FN_NEGATE, VW'(0), 32'sd7);
        send_word(mau_pkg::FN_NEGATE, amax, -32'sd1);
        send_word(mau_pkg::FN_MUL, amax, -32'sd2147483647);
        send_word(mau_pkg::FN_MUL, mau_pkg::MODULUS_RESET, 32'sd3);
        send_word(mau_pkg::FN_POWER, VW'(0), 32'sd0);
        send_word(mau_pkg::FN_POWER, VW'(3), -32'sd1);
        send_word(mau_pkg::FN_POWER, VW'(0), -32'sd5);
        send_word(mau_pkg::FN_POWER, VW'(2), 32'sd2147483646);
        send_word(mau_pkg::FN_POWER, VW'(2), -32'sd2147483647);
        send_word(mau_pkg::FN_INV, VW'(0), 32'sd9);
        send_word(mau_pkg::FN_INV, VW'(1), 32'sd0);
        send_word(mau_pkg::FN_INV, mau_pkg::MODULUS_RESET - 1'b1, 32'sd0);
        send_word(mau_pkg::FN_INV, mau_pkg::MODULUS_RESET, 32'sd0);
        send_word(mau_pkg::FN_DIVIDE, VW'(5), 32'sd0);
        send_word(mau_pkg::FN_DIVIDE, amax, -32'sd1);
        send_word(mau_pkg::FN_DIVIDE, VW'(7), 32'sd1000000007);

        for (int ph = 0; ph < 6; ph++) begin
            write_modulus(moduli[ph]);
            case (ph / 2)
                0: begin tx_idle_pct = 10; rx_idle_pct = 85; end
                1: begin tx_idle_pct = 85; rx_idle_pct = 10; end
                default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
            endcase
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (ph == 4 && k == 10) hold_req = 1'b1;
                f = FW'($urandom_range(0, 6));
                send_word(f, rand_a(), rand_b(f));
            end
        end
        req_bus.valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        $display("Sent %0d words over six moduli (2 to 2^31-1, prime and composite),",
                 words_sent);
        $display("checked %0d responses, %0d of them without an inverse.", checked, no_inverse);
        if (errors == 0) begin
            $display("modular_arithmetic_unit_top_test OK");
        end else begin
            $display("modular_arithmetic_unit_top_test NOT OK");
        end
        $finish;
    end
endmodule

// ===== files.f =====
rtl/mau_pkg.sv
rtl/mau_in_if.sv
rtl/mau_out_if.sv
rtl/mau_dp.sv
rtl/mau_ctrl.sv
rtl/modular_arithmetic_unit_top.sv
verif/mau_checker.sv
verif/modular_arithmetic_unit_top_test.sv
